/* rtl/bap_pkg.sv */
// ---------------------------------------------------------------------------
// bap_pkg
// Types, constants and helpers shared by the bit-aligned pattern search.
// ---------------------------------------------------------------------------
package bap_pkg;

   localparam int PAT_W     = 64;                  // longest pattern compared
   localparam int LANES     = 8;                   // alignments per byte
   localparam int WIN_BYTES = PAT_W / 8 + 2;
   localparam int WIN_W     = WIN_BYTES * 8;
   localparam int EXT_W     = WIN_W + PAT_W;       // window padded below with zeros
   localparam int SLICE_W   = PAT_W + LANES - 1;
   localparam int BIT_W     = 20;                  // track bit offset width
   localparam int IDX_W     = BIT_W - 2;           // byte index width
   localparam int LEN_W     = 7;
   localparam int KB_W      = 4;
   localparam int SEL_W     = 8;
   localparam int SW        = 21;                  // signed width for byte math
   localparam int ALIGN_W   = 3;

   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BITS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_BITS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_BITS  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } bap_req_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] match_bit;
      logic             done_res;
   } bap_rsp_type;

   // what the lanes found for one word, handed to the merge stage
   typedef struct packed {
      logic             first;
      logic             ok;      // candidate byte checked in this word
      logic             last;    // no candidate byte follows
      logic [LANES-1:0] hits;
      logic [IDX_W-1:0] c;
   } bap_eval_type;

   function automatic logic bap_elig(input logic signed [SW-1:0] x,
                                     input logic signed [SW-1:0] sb,
                                     input logic signed [SW-1:0] tsz,
                                     input logic signed [SW-1:0] wsz);
      logic r;
      r = (x == sb) || ((x > sb) && (x < tsz) && ((x - sb) < wsz));
      return r;
   endfunction

endpackage

/* rtl/bap_lane.sv */
// ---------------------------------------------------------------------------
// bap_lane
// One alignment: masked compare of the left-aligned pattern to a window slice.
// ---------------------------------------------------------------------------
module bap_lane
   import bap_pkg::*;
(
   input  logic [PAT_W-1:0] win_bits,
   input  logic [PAT_W-1:0] pat_bits,
   input  logic [PAT_W-1:0] mask_bits,
   output logic             hit
);

   assign hit = ~|((win_bits ^ pat_bits) & mask_bits);

endmodule

/* rtl/bap_merge.sv */
// ---------------------------------------------------------------------------
// bap_merge
// Picks the lowest matching alignment, tracks the search state and holds
// the result register.
// ---------------------------------------------------------------------------
module bap_merge
   import bap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic         in_valid,
   input  bap_eval_type eval,
   output logic         rsp_valid,
   output bap_rsp_type  rsp_data
);

   logic               rsp_valid_ff;
   bap_rsp_type        rsp_data_ff;
   logic               searching_ff;
   logic               searching_in;
   logic               base;
   logic               any_hit;
   logic               found_w;
   logic               done_w;
   logic [ALIGN_W-1:0] pos;
   bap_rsp_type        res;

   always_comb begin
      base    = eval.first | searching_ff;
      any_hit = |eval.hits;
      pos     = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (eval.hits[k]) begin
            pos = ALIGN_W'(k);
         end
      end
      found_w       = base & eval.ok & any_hit;
      done_w        = base & eval.ok & (any_hit | eval.last);
      res.found     = found_w;
      res.match_bit = found_w ? {eval.c[BIT_W-4:0], pos} : '0;
      res.done_res  = done_w;
      searching_in  = in_valid ? (base & ~done_w) : searching_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         searching_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= in_valid;
         searching_ff <= searching_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_found_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |-> rsp_data_ff.done_res)
      else $error("match reported without done");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (load && in_valid && done_w) |=> !searching_ff)
      else $error("search still open after done");

endmodule

/* rtl/bit_aligned_pattern_search.sv */
// ---------------------------------------------------------------------------
// bit_aligned_pattern_search
// Finds the first bit-aligned occurrence of a configured pattern in a track
// byte stream, checking eight alignments per byte in parallel lanes.
// ---------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   req_      in         valid / stall      data_byte, first_byte
//   rsp_      out        valid / stall      found, match_bit, done_res
//   csr_      in         valid / ready      index, 64-bit write data
//
// one word in and one word out per cycle while rsp_stall is low; a word's
// result passes the window stage, lane compare stage and merge register
// reset is synchronous and clears the pipeline, the search state and the
// registers; stages advance independently so empty stages keep taking words
// while rsp_stall holds a finished result; csr writes are taken every cycle
// ---------------------------------------------------------------------------
module bit_aligned_pattern_search
   import bap_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bap_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bap_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   // configuration
   logic [63:0]      pattern_ff;
   logic [LEN_W-1:0] pattern_bits_ff;
   logic [19:0]      start_bit_ff;
   logic [20:0]      track_bits_ff;
   logic [20:0]      search_bits_ff;

   // window stage
   logic             v1_ff;
   logic             first1_ff;
   logic [WIN_W-1:0] win_ff;
   logic [IDX_W-1:0] idx_ff;

   // lane stage
   logic             v2_ff;
   bap_eval_type     eval_ff;
   bap_eval_type     eval_in;

   logic adv1;
   logic adv2;
   logic adv3;
   logic accept;

   logic [LEN_W-1:0]   len;
   logic [KB_W-1:0]    kb;
   logic [PAT_W-1:0]   pat_norm;
   logic [PAT_W-1:0]   pat_mask;
   logic [5:0]         pat_shift;
   logic [EXT_W-1:0]   ext_win;
   logic [SEL_W-1:0]   sel;
   logic [SLICE_W-1:0] slice;
   logic [LANES-1:0]   hits;
   logic [LANES-1:0]   align_mask;
   logic               have;
   logic [IDX_W-1:0]   c;
   logic [21:0]        track_sum;
   logic [21:0]        search_sum;
   logic [3:0]         len_bytes;
   logic signed [SW-1:0] c_s;
   logic signed [SW-1:0] c1_s;
   logic signed [SW-1:0] sb_s;
   logic signed [SW-1:0] tsz_s;
   logic signed [SW-1:0] wsz_s;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff      <= '0;
         pattern_bits_ff <= LEN_W'(PAT_W);
         start_bit_ff    <= '0;
         track_bits_ff   <= '0;
         search_bits_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN:      pattern_ff      <= csr_data;
            CSR_PATTERN_BITS: pattern_bits_ff <= csr_data[LEN_W-1:0];
            CSR_START_BIT:    start_bit_ff    <= csr_data[19:0];
            CSR_TRACK_BITS:   track_bits_ff   <= csr_data[20:0];
            CSR_SEARCH_BITS:  search_bits_ff  <= csr_data[20:0];
            default: ;
         endcase
      end
   end

   // each stage moves when it is empty or the next one moves
   assign adv3      = ~rsp_valid | ~rsp_stall;
   assign adv2      = ~v2_ff | adv3;
   assign adv1      = ~v1_ff | adv2;
   assign req_stall = ~adv1;
   assign accept    = req_valid & adv1;

   // window stage: newest byte in the low byte, first_byte clears history
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         first1_ff <= 1'b0;
         win_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (accept) begin
            first1_ff <= req_data.first_byte;
            if (req_data.first_byte) begin
               win_ff <= {{(WIN_W-8){1'b0}}, req_data.data_byte};
               idx_ff <= '0;
            end else begin
               win_ff <= {win_ff[WIN_W-9:0], req_data.data_byte};
               if (idx_ff < IDX_MAX) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
         end
      end
   end

   // pattern length clamp, left-aligned pattern and compare mask
   always_comb begin
      if (pattern_bits_ff == '0) begin
         len = LEN_W'(1);
      end else if (pattern_bits_ff > LEN_W'(PAT_W)) begin
         len = LEN_W'(PAT_W);
      end else begin
         len = pattern_bits_ff;
      end
      pat_shift = 6'(LEN_W'(PAT_W) - len);
      pat_norm  = pattern_ff << pat_shift;
      pat_mask  = {PAT_W{1'b1}} << pat_shift;
      kb        = KB_W'(({1'b0, len} + 8'd14) >> 3);
      ext_win   = {win_ff, {PAT_W{1'b0}}};
      sel       = SEL_W'({kb, 3'b000}) + SEL_W'(PAT_W - 1);
      slice     = ext_win[sel -: SLICE_W];
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      bap_lane u_lane (
         .win_bits  (slice[SLICE_W-1-i -: PAT_W]),
         .pat_bits  (pat_norm),
         .mask_bits (pat_mask),
         .hit       (hits[i])
      );
   end

   // candidate byte eligibility
   always_comb begin
      have       = idx_ff >= IDX_W'(kb - 1'b1);
      c          = idx_ff - IDX_W'(kb - 1'b1);
      c_s        = $signed(SW'(c));
      c1_s       = c_s + SW'(1);
      sb_s       = $signed(SW'(start_bit_ff[19:3]));
      track_sum  = {1'b0, track_bits_ff} + 22'd7;
      search_sum = {1'b0, search_bits_ff} + 22'd7;
      len_bytes  = 4'(({1'b0, len} + 8'd7) >> 3);
      tsz_s      = $signed(SW'(track_sum[21:3])) - $signed(SW'(len_bytes));
      wsz_s      = (search_bits_ff != '0) ? $signed(SW'(search_sum[21:3])) : tsz_s;
      align_mask = (c_s == sb_s) ? (8'hFF << start_bit_ff[2:0]) : 8'hFF;

      eval_in.first = first1_ff;
      eval_in.ok    = have & bap_elig(c_s, sb_s, tsz_s, wsz_s);
      eval_in.last  = ~bap_elig(c1_s, sb_s, tsz_s, wsz_s);
      eval_in.hits  = hits & align_mask;
      eval_in.c     = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         eval_ff <= eval_in;
      end
   end

   bap_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (adv3),
      .in_valid  (v2_ff),
      .eval      (eval_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && rsp_valid))
      else $error("input stalled with an empty stage");

endmodule
